// ===== sv/hbf_pkg.sv =====
// ----------------------------------------------------------------------------
// hbf_pkg
// Shared types and constants for the half/bfloat16/single converter.
// ----------------------------------------------------------------------------
package hbf_pkg;

  typedef enum logic [1:0] {
    KIND_H2S  = 2'd0,
    KIND_B2S  = 2'd1,
    KIND_S2H  = 2'd2,
    KIND_S2B  = 2'd3
  } kind_t;

  localparam logic [15:0] HALF_QNAN = 16'h7e00;
  localparam logic [15:0] HALF_INF  = 16'h7c00;
  localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] operand;
  } item_t;

  // decoded fields after stage 1
  typedef struct packed {
    kind_t       kind;
    logic [31:0] operand;
    logic [3:0]  lz;        // leading zeros of half mantissa (0..9)
    logic        s_zero;    // single magnitude zero
    logic        s_nan;
    logic        s_ovf;     // ex >= 31
    logic        s_sub;     // subnormal half result: ex in -10..0
    logic        s_flush;   // ex < -10
    logic [4:0]  sh;        // subnormal shift 14..24
    logic [4:0]  hex;       // normal half exponent
    logic [31:0] bsum;      // bfloat16 rounding sum
  } dec_t;

endpackage

// ===== sv/half_bfloat_float_converter.sv =====
// ----------------------------------------------------------------------------
// half_bfloat_float_converter
// Three-stage pipelined converter between single, half and bfloat16.
// ----------------------------------------------------------------------------
// channel  signals                          direction
// input    in_valid in_stall kind operand   sink
// output   out_valid out_stall converted    source
//
// One item per cycle is accepted while in_stall is low.
// Stages: input register, decode register, result register.
// A stall freezes only the stages that hold a waiting item; bubbles fill.
// Reset clears the valid bits only.
module half_bfloat_float_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] converted
);

  hbf_pkg::item_t s0;
  hbf_pkg::dec_t  s1, dec_next;
  logic [31:0]    conv_next;
  logic           v0, v1, v2;
  logic           en0, en1, en2;

  assign en2 = !v2 || !out_stall;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign in_stall = !en0;
  assign out_valid = v2;

  hbf_decode u_dec (.d(s0), .q(dec_next));
  hbf_convert u_cvt (.d(s1), .r(conv_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
    if (en0) s0 <= '{kind: hbf_pkg::kind_t'(kind), operand: operand};
    if (en1) s1 <= dec_next;
    if (en2) converted <= conv_next;
  end

endmodule

// ===== sv/hbf_decode.sv =====
// ----------------------------------------------------------------------------
// hbf_decode
// Stage 1: field decode, exponent classification, leading-zero count.
// ----------------------------------------------------------------------------
module hbf_decode (
  input  hbf_pkg::item_t d,
  output hbf_pkg::dec_t  q
);

  logic [4:0] ex;
  logic [9:0] hm;

  always_comb begin
    hm = d.operand[9:0];
    q.kind = d.kind;
    q.operand = d.operand;
    q.lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) q.lz = 4'(9 - i);
    end
    ex = 5'({1'b0, d.operand[30:23]} - 9'd112);
    q.s_zero = (d.operand[30:0] == 31'd0);
    q.s_nan = (d.operand[30:23] == 8'hff) && (d.operand[22:0] != 23'd0);
    q.s_ovf = (d.operand[30:23] >= 8'd143);
    q.s_flush = (d.operand[30:23] < 8'd102);
    q.s_sub = !q.s_flush && (d.operand[30:23] <= 8'd112);
    q.sh = 5'(9'd126 - {1'b0, d.operand[30:23]});
    q.hex = ex;
    q.bsum = d.operand + 32'h7fff + {31'd0, d.operand[16]};
  end

endmodule

// ===== sv/hbf_convert.sv =====
// ----------------------------------------------------------------------------
// hbf_convert
// Stage 2: per-kind result assembly and rounding.
// ----------------------------------------------------------------------------
module hbf_convert (
  input  hbf_pkg::dec_t d,
  output logic [31:0]   r
);

  logic [23:0] man;
  logic [23:0] mask;
  logic [23:0] rem;
  logic [23:0] halfway;
  logic [15:0] hsub;
  logic [15:0] hv;
  logic [9:0]  nm;
  logic [7:0]  e;
  logic [15:0] h;
  logic        sgn;

  always_comb begin
    sgn = d.operand[31];
    man = {1'b1, d.operand[22:0]};
    mask = (24'd1 << d.sh) - 24'd1;
    rem = man & mask;
    halfway = 24'd1 << (d.sh - 5'd1);
    hsub = 16'(man >> d.sh);
    if (rem > halfway || (rem == halfway && hsub[0])) hsub = hsub + 16'd1;
    hv = {1'b0, d.hex, d.operand[22:13]};
    if (d.operand[12:0] > 13'h1000 || (d.operand[12:0] == 13'h1000 && hv[0]))
      hv = hv + 16'd1;
    if (d.s_zero) h = 16'd0;
    else if (d.s_ovf) h = d.s_nan ? hbf_pkg::HALF_QNAN : hbf_pkg::HALF_INF;
    else if (d.s_flush) h = 16'd0;
    else if (d.s_sub) h = hsub;
    else h = hv;
    nm = 10'(d.operand[9:0] << (d.lz + 4'd1));
    e = hbf_pkg::EXP_BIAS_DIFF - {4'd0, d.lz};
    r = 32'd0;
    case (d.kind)
      hbf_pkg::KIND_H2S: begin
        if (d.operand[14:10] == 5'd0) begin
          if (d.operand[9:0] == 10'd0) r = {d.operand[15], 31'd0};
          else r = {d.operand[15], e, nm, 13'd0};
        end else if (d.operand[14:10] == 5'h1f)
          r = {d.operand[15], 8'hff, d.operand[9:0], 13'd0};
        else
          r = {d.operand[15], 3'd0, d.operand[14:10], d.operand[9:0], 13'd0}
              + {1'b0, hbf_pkg::EXP_BIAS_DIFF, 23'd0};
      end
      hbf_pkg::KIND_B2S: r = {d.operand[15:0], 16'd0};
      hbf_pkg::KIND_S2H: r = {16'd0, sgn | h[15], h[14:0]};
      hbf_pkg::KIND_S2B: r = {16'd0, d.bsum[31:16]};
      default: r = 32'd0;
    endcase
  end

endmodule

// ===== sv/hbf_checker.sv =====
// ----------------------------------------------------------------------------
// hbf_checker
// Port-level checks for the converter.
// ----------------------------------------------------------------------------
module hbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] converted
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(converted))
    else $error("stalled item changed");
  a_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("item lost in pipeline");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");

endmodule

bind half_bfloat_float_converter hbf_checker u_chk (.*);
